// ----- hw/rtl/assert_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising clock edge, live during reset too.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/kct_pkg.sv -----
`timescale 1ns / 1ps

package kct_pkg;

	localparam int KEY_W     = 64;
	localparam int KEY_BYTES = 8;
	localparam int WORLD_W   = 32;
	localparam int VAL_W     = 32;
	localparam int MODE_W    = 3;
	localparam int STAT_W    = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_GET   = 3'd0,
		MODE_SET   = 3'd1,
		MODE_ADD   = 3'd2,
		MODE_TALLY = 3'd3,
		MODE_CLEAR = 3'd4
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_HIT  = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]   name;
		logic [KEY_W-1:0]   sub;
		logic [WORLD_W-1:0] world;
	} rec_key_t;

	// write request into the record table
	typedef struct packed {
		logic             key_en;
		logic             val_en;
		rec_key_t         key;
		logic [VAL_W-1:0] value;
	} wr_req_t;

endpackage

// ----- hw/rtl/kct_norm.sv -----
`timescale 1ns / 1ps

// Key canonical form: cut at the first zero byte, fold A..Z to lower case.
module kct_norm (
	input  logic [kct_pkg::KEY_W-1:0] key_in,
	output logic [kct_pkg::KEY_W-1:0] key_out
);

	logic       live;
	logic [7:0] b;

	always_comb begin
		live    = 1'b1;
		b       = '0;
		key_out = '0;
		for (int i = 0; i < 8; i++) begin
			b = key_in[8*i +: 8];
			if (b == 8'h00 || i >= kct_pkg::KEY_BYTES) begin
				live = 1'b0;
			end
			if (live) begin
				if (b >= 8'h41 && b <= 8'h5A) begin
					b = b + 8'h20;
				end
				key_out[8*i +: 8] = b;
			end
		end
	end

endmodule

// ----- hw/rtl/kct_table.sv -----
`timescale 1ns / 1ps

// Record storage: one read port and one write port, read data registered.
module kct_table #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [IDX_W-1:0]            rd_addr,
	output kct_pkg::rec_key_t           rd_key,
	output logic [kct_pkg::VAL_W-1:0]   rd_val,
	input  kct_pkg::wr_req_t            wr,
	input  logic [IDX_W-1:0]            wr_addr
);

	kct_pkg::rec_key_t         key_mem [DEPTH];
	logic [kct_pkg::VAL_W-1:0] val_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.key_en) begin
			key_mem[wr_addr] <= wr.key;
		end
		if (wr.val_en) begin
			val_mem[wr_addr] <= wr.value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key <= key_mem[rd_addr];
			rd_val <= val_mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/keyed_counter_table.sv -----
// get/set/add/tally scan the stored records one per cycle through the table
// read port, stopping early when get/set/add hit; clear and unused modes skip
// the scan. One transaction is handled at a time, taken only while idle.
// Reset clears the record count and output valid; table contents are not
// cleared and are never read beyond the count.
`timescale 1ns / 1ps

module keyed_counter_table #(
	parameter int ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// name_key[63:0], sub_key[127:64], world[159:128], amount[191:160]
	input  logic [191:0] s_axis_tdata,
	// mode[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// value[31:0]
	output logic [31:0]  m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int VW    = kct_pkg::VAL_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	state_t                 state_q;
	kct_pkg::mode_t         mode_q;
	kct_pkg::rec_key_t      key_q;
	logic [VW-1:0]          amt_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       ptr_q;
	logic                   valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [VW-1:0]          hit_val_q;
	logic [VW-1:0]          acc_q;
	logic                   m_valid_q;
	logic [VW-1:0]          m_data_q;
	kct_pkg::status_t       m_stat_q;

	logic [kct_pkg::KEY_W-1:0] name_n;
	logic [kct_pkg::KEY_W-1:0] sub_n;
	kct_pkg::mode_t            in_mode;
	kct_pkg::rec_key_t         rd_key;
	logic [VW-1:0]             rd_val;
	kct_pkg::wr_req_t          wr;
	logic [IDX_W-1:0]          wr_addr;
	logic                      rd_en;
	logic                      in_acc;
	logic                      name_eq;
	logic                      full_eq;
	logic                      is_find;
	logic                      find_hit;
	logic                      tally_hit;
	logic                      full;
	logic                      out_free;
	logic                      do_finish;
	logic                      do_write;
	logic [VW-1:0]             res_val;
	kct_pkg::status_t          res_stat;

	kct_norm u_norm_name (.key_in(s_axis_tdata[63:0]),   .key_out(name_n));
	kct_norm u_norm_sub  (.key_in(s_axis_tdata[127:64]), .key_out(sub_n));

	kct_table #(.DEPTH(ENTRIES), .IDX_W(IDX_W)) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (ptr_q[IDX_W-1:0]),
		.rd_key  (rd_key),
		.rd_val  (rd_val),
		.wr      (wr),
		.wr_addr (wr_addr)
	);

	assign in_mode       = kct_pkg::mode_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign is_find = (mode_q == kct_pkg::MODE_GET) || (mode_q == kct_pkg::MODE_SET) ||
	                 (mode_q == kct_pkg::MODE_ADD);

	assign name_eq   = (rd_key.name == key_q.name);
	assign full_eq   = name_eq && (rd_key.sub == key_q.sub) && (rd_key.world == key_q.world);
	assign find_hit  = (state_q == ST_SCAN) && valid_s1 && is_find && full_eq;
	assign tally_hit = (state_q == ST_SCAN) && valid_s1 &&
	                   (mode_q == kct_pkg::MODE_TALLY) && name_eq;
	assign rd_en     = (state_q == ST_SCAN) && (ptr_q < count_q) && !find_hit;

	assign full      = (count_q >= CNT_W'(ENTRIES));
	assign out_free  = !m_valid_q || m_axis_tready;
	assign do_finish = (state_q == ST_RESULT) && out_free;
	assign do_write  = do_finish && (hit_q || !full) &&
	                   ((mode_q == kct_pkg::MODE_SET) || (mode_q == kct_pkg::MODE_ADD));

	always_comb begin
		res_val  = '0;
		res_stat = kct_pkg::STAT_MISS;
		unique case (mode_q)
			kct_pkg::MODE_GET: begin
				if (hit_q) begin
					res_val  = hit_val_q;
					res_stat = kct_pkg::STAT_HIT;
				end
			end
			kct_pkg::MODE_SET: begin
				if (hit_q) begin
					res_val  = amt_q;
					res_stat = kct_pkg::STAT_HIT;
				end else if (full) begin
					res_stat = kct_pkg::STAT_FULL;
				end else begin
					res_val  = amt_q;
				end
			end
			kct_pkg::MODE_ADD: begin
				if (hit_q) begin
					res_val  = hit_val_q + amt_q;
					res_stat = kct_pkg::STAT_HIT;
				end else if (full) begin
					res_stat = kct_pkg::STAT_FULL;
				end else begin
					res_val  = amt_q;
				end
			end
			kct_pkg::MODE_TALLY: begin
				res_val  = acc_q;
				res_stat = hit_q ? kct_pkg::STAT_HIT : kct_pkg::STAT_MISS;
			end
			kct_pkg::MODE_CLEAR: begin
				res_stat = kct_pkg::STAT_HIT;
			end
			default: begin
				res_stat = kct_pkg::STAT_MISS;
			end
		endcase
	end

	// hit overwrites the matched value, miss appends a full record
	always_comb begin
		wr.key_en = do_write && !hit_q;
		wr.val_en = do_write;
		wr.key    = key_q;
		wr.value  = res_val;
		wr_addr   = hit_q ? hit_idx_q : count_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			valid_s1  <= 1'b0;
			hit_q     <= 1'b0;
			m_valid_q <= 1'b0;
			mode_q    <= kct_pkg::MODE_GET;
		end else begin
			valid_s1 <= rd_en;
			idx_s1   <= ptr_q[IDX_W-1:0];
			if (m_axis_tready && !do_finish) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						mode_q      <= in_mode;
						key_q.name  <= name_n;
						key_q.sub   <= sub_n;
						key_q.world <= s_axis_tdata[159:128];
						amt_q       <= s_axis_tdata[191:160];
						ptr_q       <= '0;
						acc_q       <= '0;
						hit_q       <= 1'b0;
						if (in_mode == kct_pkg::MODE_GET || in_mode == kct_pkg::MODE_SET ||
						    in_mode == kct_pkg::MODE_ADD || in_mode == kct_pkg::MODE_TALLY) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (tally_hit) begin
						acc_q <= acc_q + rd_val;
						hit_q <= 1'b1;
					end
					if (find_hit) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
						hit_val_q <= rd_val;
						state_q   <= ST_RESULT;
					end else if (!valid_s1 && ptr_q >= count_q) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= res_val;
						m_stat_q  <= res_stat;
						state_q   <= ST_IDLE;
						if (mode_q == kct_pkg::MODE_CLEAR) begin
							count_q <= '0;
						end else if (wr.key_en) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_stat_q;

endmodule

// ----- hw/rtl/kct_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// a stalled result stays offered
	`CHK_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

	// the block is busy in the cycle after it takes a transaction
	`CHK_ASSERT(a_busy_after_in, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken on consecutive cycles")

	// a full table appends nothing and reports zero
	`CHK_ASSERT(a_full_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser == kct_pkg::STAT_FULL |-> m_axis_tdata == 32'd0, "full status with nonzero value")

	`CHK_ASSERT_ALWAYS(a_status_code, clk, m_axis_tvalid |-> m_axis_tuser != 2'd3, "undefined status code")

endmodule

bind keyed_counter_table kct_checker u_kct_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import kct_pkg::*;

	localparam int ENTRIES     = 64;
	localparam int IDLE_PCT    = 21;
	localparam int STALL_LIMIT = 4000;
	localparam int POOL_SIZE   = 12;
	localparam int MAX_REPORTS = 10;

	// codes the block does not define; it must answer them with a miss
	localparam logic [MODE_W-1:0] MODE_RSVD_5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

	localparam logic [31:0] W_GLOBAL = 32'hFFFF_FFFF;
	localparam logic [31:0] W_MIN    = 32'h8000_0000;
	localparam logic [31:0] W_MAX    = 32'h7FFF_FFFF;

	// keys are written first byte lowest
	localparam logic [63:0] KEY_SCORE      = 64'h0000_0065_726F_6373; // "score"
	localparam logic [63:0] KEY_SCORE_JUNK = 64'h5AA5_0045_524F_4353; // "SCORE", junk past NUL
	localparam logic [63:0] KEY_LIVES      = 64'h0000_0073_6576_696C; // "lives"
	localparam logic [63:0] KEY_EDGE_UP    = 64'h0000_0000_5B5A_4140; // "@AZ["
	localparam logic [63:0] KEY_EDGE_LOW   = 64'h0000_0000_5B7A_6140; // "@az["
	localparam logic [63:0] KEY_EDGE_TICK  = 64'h0000_0000_5B7A_6160; // "`az["
	localparam logic [63:0] KEY_LEAD_NUL   = 64'hFFFF_FFFF_FFFF_FF00; // folds to empty
	localparam logic [63:0] KEY_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [KEY_W-1:0]   name;
		logic [KEY_W-1:0]   sub;
		logic [WORLD_W-1:0] world;
		logic [VAL_W-1:0]   amount;
	} table_op_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		status_t          status;
	} reply_t;

	typedef struct packed {
		table_op_t op;
		bit        typed;
		reply_t    want;
	} directed_row_t;

	localparam int N_DIRECTED = 24;
	localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{'{MODE_GET,    KEY_SCORE,      64'h0,        W_GLOBAL,     32'd5},
			1'b1, '{32'h0000_0000, STAT_MISS}},
		'{'{MODE_TALLY,  KEY_SCORE,      64'h0,        W_GLOBAL,     32'd0},
			1'b1, '{32'h0000_0000, STAT_MISS}},
		'{'{MODE_SET,    KEY_SCORE,      64'h0,        W_GLOBAL,     32'h7FFF_FFFF},
			1'b1, '{32'h7FFF_FFFF, STAT_MISS}},
		'{'{MODE_ADD,    KEY_SCORE_JUNK, 64'h0,        W_GLOBAL,     32'd1},
			1'b1, '{32'h8000_0000, STAT_HIT}},
		'{'{MODE_GET,    KEY_SCORE,      64'h0,        W_GLOBAL,     32'hFFFF_FFFF},
			1'b1, '{32'h8000_0000, STAT_HIT}},
		'{'{MODE_SET,    KEY_SCORE,      KEY_LIVES,    32'h0,        32'h8000_0000},
			1'b1, '{32'h8000_0000, STAT_MISS}},
		'{'{MODE_ADD,    KEY_ONES,       KEY_ONES,     W_MAX,        32'hFFFF_FFFF},
			1'b1, '{32'hFFFF_FFFF, STAT_MISS}},
		'{'{MODE_ADD,    KEY_ONES,       KEY_ONES,     W_MAX,        32'hFFFF_FFFF},
			1'b1, '{32'hFFFF_FFFE, STAT_HIT}},
		'{'{MODE_SET,    64'h0,          64'h0,        W_MIN,        32'h0},
			1'b1, '{32'h0000_0000, STAT_MISS}},
		'{'{MODE_GET,    KEY_LEAD_NUL,   KEY_LEAD_NUL, W_MIN,        32'h0},
			1'b1, '{32'h0000_0000, STAT_HIT}},
		'{'{MODE_SET,    KEY_EDGE_UP,    KEY_LIVES,    32'd7,        32'd1234},
			1'b1, '{32'd1234,      STAT_MISS}},
		'{'{MODE_GET,    KEY_EDGE_LOW,   KEY_LIVES,    32'd7,        32'h0},
			1'b1, '{32'd1234,      STAT_HIT}},
		'{'{MODE_GET,    KEY_EDGE_TICK,  KEY_LIVES,    32'd7,        32'h0},
			1'b1, '{32'h0000_0000, STAT_MISS}},
		// two records at 0x80000000 under "score": the sum wraps to zero
		'{'{MODE_TALLY,  KEY_SCORE,      KEY_ONES,     W_MAX,        32'h0},
			1'b1, '{32'h0000_0000, STAT_HIT}},
		'{'{MODE_SET,    KEY_SCORE,      64'h0,        32'd3,        32'h1234_5678},
			1'b0, '0},
		'{'{MODE_TALLY,  KEY_SCORE_JUNK, 64'h0,        32'h0,        32'h0},
			1'b0, '0},
		'{'{MODE_RSVD_5, KEY_SCORE,      64'h0,        W_GLOBAL,     32'hFFFF_FFFF},
			1'b1, '{32'h0000_0000, STAT_MISS}},
		'{'{MODE_RSVD_6, KEY_ONES,       KEY_ONES,     W_GLOBAL,     32'hFFFF_FFFF},
			1'b1, '{32'h0000_0000, STAT_MISS}},
		'{'{MODE_RSVD_7, KEY_SCORE,      64'h0,        W_GLOBAL,     32'h5555_AAAA},
			1'b1, '{32'h0000_0000, STAT_MISS}},
		'{'{MODE_CLEAR,  KEY_ONES,       KEY_ONES,     W_MAX,        32'hFFFF_FFFF},
			1'b1, '{32'h0000_0000, STAT_HIT}},
		'{'{MODE_GET,    KEY_SCORE,      64'h0,        W_GLOBAL,     32'h0},
			1'b1, '{32'h0000_0000, STAT_MISS}},
		'{'{MODE_TALLY,  KEY_SCORE,      64'h0,        W_GLOBAL,     32'h0},
			1'b1, '{32'h0000_0000, STAT_MISS}},
		'{'{MODE_ADD,    KEY_SCORE,      64'h0,        W_GLOBAL,     32'h8000_0000},
			1'b1, '{32'h8000_0000, STAT_MISS}},
		'{'{MODE_SET,    KEY_SCORE,      64'h0,        W_GLOBAL,     32'd7},
			1'b1, '{32'h0000_0007, STAT_HIT}}
	};

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	// shadow of the record table
	logic [63:0] tbl_name  [ENTRIES];
	logic [63:0] tbl_sub   [ENTRIES];
	logic [31:0] tbl_world [ENTRIES];
	logic [31:0] tbl_value [ENTRIES];
	int          tbl_count = 0;

	reply_t pending_replies [$];

	int idle_pct = IDLE_PCT;
	int mismatches = 0;
	int replies_seen = 0;
	int stall_cycles = 0;
	int peak_entries = 0;
	int mode_seen [8] = '{default: 0};
	int status_seen [4] = '{default: 0};

	logic [63:0] pool_name  [POOL_SIZE];
	logic [63:0] pool_sub   [POOL_SIZE];
	logic [31:0] pool_world [POOL_SIZE];
	logic [63:0] base_names [4];

	keyed_counter_table #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cut at the first NUL, fold A..Z to lower case
	function automatic logic [63:0] fold_key(logic [63:0] k);
		logic [63:0] r;
		logic [7:0]  b;
		bit          ended;
		r = '0;
		ended = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			b = k[8*i +: 8];
			if (b == 8'h00)
				ended = 1'b1;
			if (!ended) begin
				if (b >= 8'h41 && b <= 8'h5A)
					b = b + 8'h20;
				r[8*i +: 8] = b;
			end
		end
		return r;
	endfunction

	// apply one transaction to the shadow table and return what the block must answer
	function automatic reply_t table_reply(table_op_t op);
		reply_t      r;
		logic [63:0] nk;
		logic [63:0] sk;
		int          hit;
		nk = fold_key(op.name);
		sk = fold_key(op.sub);
		r.value = '0;
		r.status = STAT_MISS;
		hit = -1;
		case (op.mode)
			MODE_GET, MODE_SET, MODE_ADD: begin
				for (int i = 0; i < tbl_count; i++)
					if (hit < 0 && tbl_name[i] == nk && tbl_sub[i] == sk &&
					    tbl_world[i] == op.world)
						hit = i;
				if (hit >= 0) begin
					r.status = STAT_HIT;
					if (op.mode == MODE_SET)
						tbl_value[hit] = op.amount;
					else if (op.mode == MODE_ADD)
						tbl_value[hit] = tbl_value[hit] + op.amount;
					r.value = tbl_value[hit];
				end else if (op.mode != MODE_GET) begin
					if (tbl_count >= ENTRIES) begin
						r.status = STAT_FULL;
					end else begin
						tbl_name[tbl_count]  = nk;
						tbl_sub[tbl_count]   = sk;
						tbl_world[tbl_count] = op.world;
						tbl_value[tbl_count] = op.amount;
						tbl_count++;
						r.value = op.amount;
					end
				end
			end
			MODE_TALLY: begin
				for (int i = 0; i < tbl_count; i++)
					if (tbl_name[i] == nk) begin
						r.value = r.value + tbl_value[i];
						r.status = STAT_HIT;
					end
			end
			MODE_CLEAR: begin
				tbl_count = 0;
				r.status = STAT_HIT;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] ascii_key(int len);
		logic [63:0] k;
		k = '0;
		for (int i = 0; i < len; i++)
			k[8*i +: 8] = 8'($urandom_range(8'h30, 8'h7E));
		return k;
	endfunction

	// same key after folding: random case flips, maybe junk past the NUL
	function automatic logic [63:0] variant_key(logic [63:0] k);
		logic [63:0] v;
		logic [7:0]  b;
		bit          ended;
		bit          junk;
		v = k;
		ended = 1'b0;
		junk = 1'($urandom_range(1));
		for (int i = 0; i < 8; i++) begin
			b = v[8*i +: 8];
			if (ended) begin
				if (junk)
					v[8*i +: 8] = 8'($urandom);
			end else if (b == 8'h00) begin
				ended = 1'b1;
			end else if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
			             $urandom_range(1) == 1) begin
				v[8*i +: 8] = b ^ 8'h20;
			end
		end
		return v;
	endfunction

	// called just after a falling edge; returns just after the falling edge that
	// follows acceptance, with tvalid still high
	task automatic push_op(input table_op_t op, input bit typed, input reply_t typed_reply);
		reply_t r;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {op.amount, op.world, op.sub, op.name};
		s_axis_tuser  <= op.mode;
		do @(posedge clk); while (!s_axis_tready);
		r = table_reply(op);
		pending_replies.push_back(typed ? typed_reply : r);
		mode_seen[op.mode]++;
		status_seen[int'(r.status)]++;
		if (tbl_count > peak_entries)
			peak_entries = tbl_count;
		@(negedge clk);
	endtask

	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_replies.size() != 0);
	endtask

	always @(negedge clk)
		m_axis_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			replies_seen++;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected transaction: value %h status %0d",
						m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_replies.pop_front();
				if (m_axis_tdata !== want.value) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("reply %0d value: expected %h, got %h",
							replies_seen, want.value, m_axis_tdata);
				end
				if (m_axis_tuser !== want.status) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("reply %0d status: expected %0d, got %0d",
							replies_seen, want.status, m_axis_tuser);
				end
			end
		end
	end

	// watchdog: cycles without any transaction on either side
	always @(posedge clk) begin
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles, %0d replies outstanding",
				stall_cycles, pending_replies.size());
			$display("[keyed_counter_table] ERROR");
			$finish;
		end else if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
		             (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		table_op_t op;
		int        pick;
		int        slot;
		int        n;
		int        extra;
		bit        fill_round;
		bit        fresh;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;

		for (int j = 0; j < 4; j++)
			base_names[j] = ascii_key($urandom_range(1, KEY_BYTES));
		for (int j = 0; j < POOL_SIZE; j++) begin
			pool_name[j] = base_names[j % 4];
			pool_sub[j] = ($urandom_range(1) == 0) ? 64'h0 :
				ascii_key($urandom_range(1, KEY_BYTES));
			case ($urandom_range(2))
				0: pool_world[j] = W_GLOBAL;
				1: pool_world[j] = 32'($urandom_range(3));
				default: pool_world[j] = $urandom;
			endcase
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			push_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		// five rounds from an empty table; rounds 1 and 3 run it into the full state,
		// round 2 runs with no idling on either side
		for (int rnd = 0; rnd < 5; rnd++) begin
			fill_round = (rnd == 1 || rnd == 3);
			if (rnd == 2)
				drain_replies();
			idle_pct = (rnd == 2) ? 0 : IDLE_PCT;
			op = '0;
			op.mode = MODE_CLEAR;
			push_op(op, 1'b0, '0);
			n = 0;
			extra = 0;
			while (fill_round ? (extra < 30) : (n < 130)) begin
				pick = $urandom_range(99);
				fresh = 1'b0;
				if (fill_round && tbl_count < ENTRIES && pick < 90) begin
					op.mode = ($urandom_range(1) == 0) ? MODE_SET : MODE_ADD;
					fresh = 1'b1;
				end else if (pick < 2) begin
					op.mode = MODE_CLEAR;
				end else if (pick < 10) begin
					op.mode = MODE_TALLY;
					fresh = ($urandom_range(6) == 0);
				end else if (pick < 13) begin
					op.mode = 3'($urandom_range(MODE_RSVD_5, MODE_RSVD_7));
				end else begin
					op.mode = 3'($urandom_range(MODE_GET, MODE_ADD));
					fresh = ($urandom_range(3) == 0);
				end

				if (fresh) begin
					op.name = ($urandom_range(1) == 0) ? {$urandom, $urandom} :
						ascii_key($urandom_range(1, KEY_BYTES));
					case ($urandom_range(2))
						0: op.sub = 64'h0;
						1: op.sub = {$urandom, $urandom};
						default: op.sub = ascii_key($urandom_range(1, KEY_BYTES));
					endcase
					case ($urandom_range(3))
						0: op.world = W_GLOBAL;
						1: op.world = 32'($urandom_range(3));
						default: op.world = $urandom;
					endcase
				end else begin
					slot = $urandom_range(POOL_SIZE - 1);
					op.name  = variant_key(pool_name[slot]);
					op.sub   = variant_key(pool_sub[slot]);
					op.world = pool_world[slot];
				end

				case ($urandom_range(9))
					0: op.amount = 32'h7FFF_FFFF;
					1: op.amount = 32'h8000_0000;
					2: op.amount = 32'hFFFF_FFFF;
					3: op.amount = 32'h0000_0001;
					default: op.amount = $urandom;
				endcase

				push_op(op, 1'b0, '0);
				n++;
				if (fill_round && tbl_count >= ENTRIES)
					extra++;
				if (rnd == 4 && n == 60)
					drain_replies();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 16) @(posedge clk);

		$display("ran %0d transactions: get %0d, set %0d, add %0d, tally %0d, clear %0d, undefined %0d",
			mode_seen.sum(), mode_seen[MODE_GET], mode_seen[MODE_SET], mode_seen[MODE_ADD],
			mode_seen[MODE_TALLY], mode_seen[MODE_CLEAR],
			mode_seen[MODE_RSVD_5] + mode_seen[MODE_RSVD_6] + mode_seen[MODE_RSVD_7]);
		$display("replies: %0d hit, %0d miss, %0d full; peak %0d records; %0d mismatches",
			status_seen[STAT_HIT], status_seen[STAT_MISS], status_seen[STAT_FULL],
			peak_entries, mismatches);
		if (mismatches == 0)
			$display("[keyed_counter_table] OK");
		else
			$display("[keyed_counter_table] ERROR");
		$finish;
	end

endmodule

// ----- keyed_counter_table.f -----
+incdir+hw/rtl
hw/rtl/kct_pkg.sv
hw/rtl/kct_norm.sv
hw/rtl/kct_table.sv
hw/rtl/keyed_counter_table.sv
hw/rtl/kct_checker.sv
bench/tb.sv
